/* rtl/bsm_pkg.sv */
// shared types, decode codes and timer constants for the bank mapper
`default_nettype none

package bsm_pkg;

   localparam int unsigned PrescalePeriod = 114;

   localparam logic [6:0] PRESCALE_PERIOD = 7'(PrescalePeriod);
   localparam logic [6:0] TICK_MAX        = 7'd114;
   localparam logic [6:0] PRESCALER_MAX   = 7'd127;
   localparam logic [7:0] COUNT_MAX       = 8'hFF;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // address[15:12] regions
   localparam logic [3:0] REGION_PRG_LOW   = 4'h8;
   localparam logic [3:0] REGION_PRG_HIGH  = 4'hA;
   localparam logic [3:0] REGION_CHR_FIRST = 4'hB;
   localparam logic [3:0] REGION_CHR_LAST  = 4'hE;
   localparam logic [3:0] REGION_IRQ       = 4'hF;

   // address[3:2] codes inside the irq region
   localparam logic [1:0] IRQ_LATCH_LOW  = 2'b00;
   localparam logic [1:0] IRQ_LATCH_HIGH = 2'b01;
   localparam logic [1:0] IRQ_CONTROL    = 2'b10;
   localparam logic [1:0] IRQ_ACK        = 2'b11;

   typedef struct packed {
      logic        command;
      logic [15:0] address;
      logic [7:0]  data;
      logic [6:0]  tick_cycles;
   } item_type;

   typedef struct packed {
      logic [7:0] prg_bank_low;
      logic [7:0] prg_bank_high;
      logic       chr_changed;
      logic [2:0] chr_slot;
      logic [7:0] chr_bank;
      logic       irq_out;
   } result_type;

endpackage

`default_nettype wire

/* rtl/bsm_core.sv */
// mapper state: bank registers, irq timer and the per-beat update
`default_nettype none

module bsm_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire bsm_pkg::item_type    item,
   output bsm_pkg::result_type       result
);

   logic [7:0] prg_low_ff, prg_low_in;
   logic [7:0] prg_high_ff, prg_high_in;
   logic [7:0] chr_banks_ff [8];
   logic [7:0] latch_ff, latch_in;
   logic [7:0] count_ff, count_in;
   logic [1:0] enable_ff, enable_in;
   logic [6:0] prescaler_ff, prescaler_in;
   logic       irq_ff, irq_in;

   logic [3:0] region;
   logic [1:0] irq_code;
   logic [2:0] slot;
   logic [7:0] chr_old;
   logic [7:0] chr_new;
   logic       chr_write;
   logic [6:0] cycles;
   logic [7:0] sum;
   logic [7:0] sum_wrapped;
   logic       wrap;

   assign region   = item.address[15:12];
   assign irq_code = item.address[3:2];
   assign slot     = {2'(region - bsm_pkg::REGION_CHR_FIRST), item.address[3]};
   assign chr_old  = chr_banks_ff[slot];
   assign chr_new  = item.address[2] ? {item.data[3:0], chr_old[3:0]}
                                     : {chr_old[7:4], item.data[3:0]};

   // prescaler arithmetic for a tick beat
   assign cycles      = (item.tick_cycles > bsm_pkg::TICK_MAX) ? bsm_pkg::TICK_MAX
                                                               : item.tick_cycles;
   assign sum         = {1'b0, prescaler_ff} + {1'b0, cycles};
   assign wrap        = sum >= {1'b0, bsm_pkg::PRESCALE_PERIOD};
   assign sum_wrapped = wrap ? sum - {1'b0, bsm_pkg::PRESCALE_PERIOD} : sum;

   always_comb begin
      prg_low_in   = prg_low_ff;
      prg_high_in  = prg_high_ff;
      latch_in     = latch_ff;
      count_in     = count_ff;
      enable_in    = enable_ff;
      prescaler_in = prescaler_ff;
      irq_in       = irq_ff;
      chr_write    = 1'b0;
      if (item.command == bsm_pkg::CMD_TICK) begin
         if (enable_ff[1]) begin
            if (wrap) begin
               if (count_ff == bsm_pkg::COUNT_MAX) begin
                  count_in  = latch_ff;
                  enable_in = {enable_ff[0], enable_ff[0]};
                  irq_in    = 1'b1;
               end else begin
                  count_in = count_ff + 8'd1;
               end
            end
            prescaler_in = (sum_wrapped > {1'b0, bsm_pkg::PRESCALER_MAX})
                           ? bsm_pkg::PRESCALER_MAX : sum_wrapped[6:0];
         end
      end else begin
         unique case (region) inside
            bsm_pkg::REGION_PRG_LOW: begin
               prg_low_in = item.data;
            end
            bsm_pkg::REGION_PRG_HIGH: begin
               prg_high_in = item.data;
            end
            [bsm_pkg::REGION_CHR_FIRST:bsm_pkg::REGION_CHR_LAST]: begin
               chr_write = 1'b1;
            end
            bsm_pkg::REGION_IRQ: begin
               unique case (irq_code)
                  bsm_pkg::IRQ_LATCH_LOW: begin
                     latch_in = {latch_ff[7:4], item.data[3:0]};
                  end
                  bsm_pkg::IRQ_LATCH_HIGH: begin
                     latch_in = {item.data[3:0], latch_ff[3:0]};
                  end
                  bsm_pkg::IRQ_CONTROL: begin
                     enable_in = item.data[1:0];
                     if (item.data[1]) begin
                        count_in     = latch_ff;
                        prescaler_in = '0;
                     end
                     irq_in = 1'b0;
                  end
                  bsm_pkg::IRQ_ACK: begin
                     enable_in = {enable_ff[0], enable_ff[0]};
                     irq_in    = 1'b0;
                  end
                  default: begin
                     irq_in = irq_ff;
                  end
               endcase
            end
            default: begin
               irq_in = irq_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_low_ff   <= 8'd0;
         prg_high_ff  <= 8'd1;
         latch_ff     <= '0;
         count_ff     <= '0;
         enable_ff    <= '0;
         prescaler_ff <= '0;
         irq_ff       <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chr_banks_ff[i] <= 8'(i);
         end
      end else if (step) begin
         prg_low_ff   <= prg_low_in;
         prg_high_ff  <= prg_high_in;
         latch_ff     <= latch_in;
         count_ff     <= count_in;
         enable_ff    <= enable_in;
         prescaler_ff <= prescaler_in;
         irq_ff       <= irq_in;
         if (chr_write) begin
            chr_banks_ff[slot] <= chr_new;
         end
      end
   end

   always_comb begin
      result.prg_bank_low  = prg_low_in;
      result.prg_bank_high = prg_high_in;
      result.chr_changed   = chr_write;
      result.chr_slot      = chr_write ? slot : '0;
      result.chr_bank      = chr_write ? chr_new : '0;
      result.irq_out       = irq_in;
   end

endmodule

`default_nettype wire

/* rtl/bank_switch_mapper_with_irq_timer.sv */
// cartridge bank mapper with cycle-driven irq timer, top level
//
// req channel: one beat is either a cpu bus write (req_command = 0, with
// req_address and req_data) or a tick of elapsed cpu cycles
// (req_command = 1, with req_tick_cycles, saturating at 114).
// rsp channel: exactly one beat per req beat, in order, carrying both
// program banks, the character bank that the write changed (if any) and
// the irq line level after the item.
// path: a req beat is held in the input register, passes the state update
// stage and is registered in the result register before it shows on rsp;
// throughput is one beat per cycle while rsp is not stalled, set by
// the single state update stage between the input and result registers.
// the input register can still take a beat while a result waits on rsp; when
// rsp is stalled with both registers full, req_stall rises in the same
// cycle and nothing is lost.
// reset: program banks 0 and 1, character window i on bank i, irq timer
// disabled with latch, counter and prescaler cleared, irq line low, both
// registers empty.
`default_nettype none

module bank_switch_mapper_with_irq_timer (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [15:0] req_address,
   input  wire logic [7:0]  req_data,
   input  wire logic [6:0]  req_tick_cycles,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_prg_bank_low,
   output logic [7:0]       rsp_prg_bank_high,
   output logic             rsp_chr_changed,
   output logic [2:0]       rsp_chr_slot,
   output logic [7:0]       rsp_chr_bank,
   output logic             rsp_irq_out
);

   logic                 stage_valid_ff, stage_valid_in;
   bsm_pkg::item_type    item_ff, item_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   bsm_pkg::result_type  result_ff, result_in;
   bsm_pkg::result_type  core_result;
   bsm_pkg::item_type    req_item;

   logic out_hold;
   logic stage_fire;
   logic req_take;

   assign req_item.command     = req_command;
   assign req_item.address     = req_address;
   assign req_item.data        = req_data;
   assign req_item.tick_cycles = req_tick_cycles;

   assign out_hold   = rsp_valid_ff & rsp_stall;
   assign stage_fire = stage_valid_ff & ~out_hold;
   assign req_stall  = stage_valid_ff & out_hold;
   assign req_take   = req_valid & ~req_stall;

   assign stage_valid_in = req_take | (stage_valid_ff & out_hold);
   assign item_in        = req_take ? req_item : item_ff;
   assign rsp_valid_in   = stage_fire | out_hold;
   assign result_in      = stage_fire ? core_result : result_ff;

   bsm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (stage_fire),
      .item   (item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         result_ff      <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         result_ff      <= result_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_prg_bank_low  = result_ff.prg_bank_low;
   assign rsp_prg_bank_high = result_ff.prg_bank_high;
   assign rsp_chr_changed   = result_ff.chr_changed;
   assign rsp_chr_slot      = result_ff.chr_slot;
   assign rsp_chr_bank      = result_ff.chr_bank;
   assign rsp_irq_out       = result_ff.irq_out;

   // irq only rises on a result built from a tick beat
   a_irq_rise_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(result_ff.irq_out) |->
         $past(stage_fire) && $past(item_ff.command) == bsm_pkg::CMD_TICK)
      else $error("irq rose without a tick beat");

   // a result without a character update carries zero slot and bank
   a_chr_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.chr_changed |->
         result_ff.chr_slot == '0 && result_ff.chr_bank == '0)
      else $error("character fields set without an update");

   // an ack or control write always leaves the irq line low
   a_ack_clears_irq: assert property (@(posedge clock) disable iff (reset)
      stage_fire && item_ff.command == bsm_pkg::CMD_WRITE &&
      item_ff.address[15:12] == bsm_pkg::REGION_IRQ && item_ff.address[3]
      |=> !result_ff.irq_out)
      else $error("irq still high after control or ack write");

endmodule

`default_nettype wire
